[rtl/sdbc_pkg.sv]
// ----------------------------------------------------------------------------
// sdbc_pkg
// Shared constants and types for the descriptor binding checker.
// ----------------------------------------------------------------------------
package sdbc_pkg;

    localparam int DECO_ENTRIES_DEF  = 64;
    localparam int PTR_ENTRIES_DEF   = 64;
    localparam int VAR_ENTRIES_DEF   = 32;
    localparam int IMAGE_ENTRIES_DEF = 16;

    localparam logic [31:0] MAGIC_WORD         = 32'h0723_0203;
    localparam logic [15:0] OP_TYPE_POINTER    = 16'd32;
    localparam logic [15:0] OP_TYPE_SAMPLED_IMAGE = 16'd27;
    localparam logic [15:0] OP_VARIABLE        = 16'd59;
    localparam logic [15:0] OP_DECORATE        = 16'd71;
    localparam logic [31:0] DEC_BINDING        = 32'd33;
    localparam logic [31:0] DEC_SET            = 32'd34;
    localparam logic [31:0] CLASS_UNIFORM_CONSTANT = 32'd0;
    localparam logic [31:0] CLASS_UNIFORM      = 32'd2;
    localparam logic [31:0] CLASS_STORAGE_BUFFER = 32'd12;

    localparam logic [2:0] VERDICT_OK         = 3'd0;
    localparam logic [2:0] VERDICT_BAD_HEADER = 3'd1;
    localparam logic [2:0] VERDICT_TRUNCATED  = 3'd2;
    localparam logic [2:0] VERDICT_BAD_DECL   = 3'd3;
    localparam logic [2:0] VERDICT_BINDING    = 3'd4;
    localparam logic [2:0] VERDICT_OVERFLOW   = 3'd5;

    // Request from the word parser to the table engine.
    typedef struct packed {
        logic        commit;     // one finished instruction to record
        logic        judge;      // final check after the last word
        logic [15:0] opcode;
        logic [15:0] length;
        logic [31:0] op1;
        logic [31:0] op2;
        logic [31:0] op3;
        logic        pre_valid;  // a verdict is already settled by the parser
        logic [2:0]  pre_verdict;
    } sdbc_req_t;

endpackage

[rtl/spirv_descriptor_binding_checker_top.sv]
// ----------------------------------------------------------------------------
// spirv_descriptor_binding_checker_top
// Header check, instruction split and binding check of a word stream.
// ----------------------------------------------------------------------------
// Channel   | Direction | Payload
// s_axis    | in        | tdata = module_word[31:0], tlast = last_word
// m_axis    | out       | tdata = verdict[2:0], failing_binding[34:3], zeros
// cfg       | in        | cfg_data = vertex_mode
//
// A word that completes no instruction is taken without a search. A word that
// completes a tracked instruction starts a linear id search of its table
// memory, and the next word waits until it ends. The last word runs the final
// check: per variable a search of the decoration, pointer, seen and image
// tables. Reset sets vertex_mode to 1 and empties all tables. A stalled result
// holds in the output register while the next stream is already accepted, up
// to its own last word.
// ----------------------------------------------------------------------------
module spirv_descriptor_binding_checker_top
    import sdbc_pkg::*;
#(
    parameter int DECO_ENTRIES  = DECO_ENTRIES_DEF,
    parameter int PTR_ENTRIES   = PTR_ENTRIES_DEF,
    parameter int VAR_ENTRIES   = VAR_ENTRIES_DEF,
    parameter int IMAGE_ENTRIES = IMAGE_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // module_word
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // verdict[2:0], failing_binding[34:3], zeros
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic        vertex_mode_reg;
    logic [2:0]  word_position_reg;
    logic        header_bad_reg;
    logic [15:0] words_remaining_reg;
    logic [15:0] length_reg, opcode_reg;
    logic [31:0] op1_reg, op2_reg, op3_reg;
    logic        truncated_reg;

    logic        eng_busy, eng_res_valid;
    logic [2:0]  eng_verdict;
    logic [31:0] eng_binding;
    logic        req_valid;
    sdbc_req_t   req;

    logic        out_valid_reg;
    logic [39:0] out_data_reg;

    assign cfg_ready = 1'b1;

    // A word is refused while the engine works, while the final check of the
    // previous stream still waits for the engine, or while a verdict would
    // find the output register still occupied.
    logic judge_pend_reg;
    assign s_axis_tready = !eng_busy && !judge_pend_reg && !(s_axis_tlast && out_valid_reg);
    logic acc;
    assign acc = s_axis_tvalid && s_axis_tready;

    // Next parser state for this word; a commit goes to the engine.
    logic [15:0] len_w, rem_next;
    logic        commit_w;
    logic [15:0] idx_w;
    assign len_w = s_axis_tdata[31:16];
    assign idx_w = length_reg - 16'd1 - words_remaining_reg;

    sdbc_req_t req_next;
    always_comb
    begin
        req_next = '0;
        req_next.opcode = opcode_reg;
        req_next.length = length_reg;
        req_next.op1 = op1_reg;
        req_next.op2 = op2_reg;
        req_next.op3 = op3_reg;
        commit_w = 1'b0;
        rem_next = words_remaining_reg;
        if (word_position_reg == 3'd5 && !truncated_reg)
        begin
            if (words_remaining_reg == 16'd0)
            begin
                req_next.opcode = s_axis_tdata[15:0];
                req_next.length = len_w;
                req_next.op1 = '0; req_next.op2 = '0; req_next.op3 = '0;
                rem_next = len_w - 16'd1;
                commit_w = len_w == 16'd1;
            end
            else
            begin
                if (idx_w == 16'd0) req_next.op1 = s_axis_tdata;
                else if (idx_w == 16'd1) req_next.op2 = s_axis_tdata;
                else if (idx_w == 16'd2) req_next.op3 = s_axis_tdata;
                rem_next = words_remaining_reg - 16'd1;
                commit_w = rem_next == 16'd0;
            end
        end
        req_next.commit = commit_w &&
            ((req_next.opcode == OP_DECORATE && req_next.length >= 16'd4) ||
             (req_next.opcode == OP_TYPE_POINTER && req_next.length == 16'd4) ||
             (req_next.opcode == OP_TYPE_SAMPLED_IMAGE && req_next.length == 16'd3) ||
             (req_next.opcode == OP_VARIABLE && req_next.length >= 16'd4));
    end

    // The last word may also commit; then the judge follows as a second request.
    sdbc_req_t judge_req_reg;
    sdbc_req_t judge_w;
    always_comb
    begin
        judge_w = req_next;
        judge_w.commit = 1'b0;
        judge_w.judge = 1'b1;
        judge_w.pre_valid = 1'b0;
        judge_w.pre_verdict = VERDICT_OK;
        if (header_bad_reg || word_position_reg < 3'd4 ||
            (word_position_reg == 3'd4 && 1'b0) ||
            (word_position_reg == 3'd0 && s_axis_tdata != MAGIC_WORD))
        begin
            judge_w.pre_valid = 1'b1; judge_w.pre_verdict = VERDICT_BAD_HEADER;
        end
        else if (word_position_reg == 3'd5 &&
                 (truncated_reg || rem_next != 16'd0 ||
                  (words_remaining_reg == 16'd0 && len_w == 16'd0)))
        begin
            judge_w.pre_valid = 1'b1; judge_w.pre_verdict = VERDICT_TRUNCATED;
        end
    end

    assign req_valid = (acc && (req_next.commit || (s_axis_tlast && !req_next.commit)))
                       || (judge_pend_reg && !eng_busy);
    always_comb
    begin
        if (judge_pend_reg) req = judge_req_reg;
        else if (req_next.commit) req = req_next;
        else req = judge_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_mode_reg <= 1'b1;
            word_position_reg <= '0; header_bad_reg <= 1'b0;
            words_remaining_reg <= '0; truncated_reg <= 1'b0;
            length_reg <= '0; opcode_reg <= '0;
            op1_reg <= '0; op2_reg <= '0; op3_reg <= '0;
            judge_pend_reg <= 1'b0; out_valid_reg <= 1'b0;
            judge_req_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready) vertex_mode_reg <= cfg_data;
            if (judge_pend_reg && !eng_busy) judge_pend_reg <= 1'b0;
            if (acc)
            begin
                if (s_axis_tlast)
                begin
                    word_position_reg <= '0; header_bad_reg <= 1'b0;
                    words_remaining_reg <= '0; truncated_reg <= 1'b0;
                    length_reg <= '0; opcode_reg <= '0;
                    op1_reg <= '0; op2_reg <= '0; op3_reg <= '0;
                    if (req_next.commit)
                    begin
                        judge_pend_reg <= 1'b1;
                        judge_req_reg <= judge_w;
                    end
                end
                else if (word_position_reg < 3'd5)
                begin
                    if (word_position_reg == 3'd0 && s_axis_tdata != MAGIC_WORD)
                        header_bad_reg <= 1'b1;
                    word_position_reg <= word_position_reg + 3'd1;
                end
                else if (!truncated_reg)
                begin
                    if (words_remaining_reg == 16'd0 && len_w == 16'd0)
                    begin
                        truncated_reg <= 1'b1;
                        length_reg <= len_w; opcode_reg <= s_axis_tdata[15:0];
                    end
                    else
                    begin
                        words_remaining_reg <= rem_next;
                        length_reg <= req_next.length; opcode_reg <= req_next.opcode;
                        op1_reg <= req_next.op1; op2_reg <= req_next.op2;
                        op3_reg <= req_next.op3;
                    end
                end
            end
            if (eng_res_valid) out_valid_reg <= 1'b1;
            else if (m_axis_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_res_valid) out_data_reg <= {5'd0, eng_binding, eng_verdict};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    sdbc_engine #(
        .DECO_ENTRIES (DECO_ENTRIES),
        .PTR_ENTRIES  (PTR_ENTRIES),
        .VAR_ENTRIES  (VAR_ENTRIES),
        .IMAGE_ENTRIES(IMAGE_ENTRIES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .vertex_mode(vertex_mode_reg),
        .req_valid  (req_valid),
        .req        (req),
        .busy       (eng_busy),
        .res_valid  (eng_res_valid),
        .res_verdict(eng_verdict),
        .res_binding(eng_binding)
    );

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        eng_res_valid |-> !out_valid_reg || m_axis_tready) else $error("verdict overrun");
    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= VERDICT_OVERFLOW) else $error("bad verdict");
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        word_position_reg <= 3'd5) else $error("header count out of range");

endmodule

[rtl/sdbc_engine.sv]
// ----------------------------------------------------------------------------
// sdbc_engine
// Table memories with sequential id search, record commit and final check.
// ----------------------------------------------------------------------------
module sdbc_engine
    import sdbc_pkg::*;
#(
    parameter int DECO_ENTRIES  = DECO_ENTRIES_DEF,
    parameter int PTR_ENTRIES   = PTR_ENTRIES_DEF,
    parameter int VAR_ENTRIES   = VAR_ENTRIES_DEF,
    parameter int IMAGE_ENTRIES = IMAGE_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        vertex_mode,
    input  logic        req_valid,
    input  sdbc_req_t   req,
    output logic        busy,
    output logic        res_valid,
    output logic [2:0]  res_verdict,
    output logic [31:0] res_binding
);

    localparam int DW = $clog2(DECO_ENTRIES);
    localparam int PW = $clog2(PTR_ENTRIES);
    localparam int VW = $clog2(VAR_ENTRIES);
    localparam int IW = $clog2(IMAGE_ENTRIES);

    // Each table memory: one read address and one write address, synchronous read.
    logic [31:0] deco_key_mem [DECO_ENTRIES];
    logic [65:0] deco_val_mem [DECO_ENTRIES]; // {bpres, spres, binding, set}
    logic [31:0] ptr_key_mem  [PTR_ENTRIES];
    logic [63:0] ptr_val_mem  [PTR_ENTRIES];  // {class, target}
    logic [31:0] var_key_mem  [VAR_ENTRIES];
    logic [63:0] var_val_mem  [VAR_ENTRIES];  // {ptr_type, class}
    logic [31:0] img_key_mem  [IMAGE_ENTRIES];
    logic [31:0] seen_mem     [VAR_ENTRIES];

    logic [DW:0] deco_used_reg;
    logic [PW:0] ptr_used_reg;
    logic [VW:0] var_used_reg;
    logic [IW:0] img_used_reg;
    logic [VW:0] seen_used_reg;
    logic        full_reg;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CSRCH  = 4'd1;  // commit: search table
    localparam logic [3:0] S_CREAD  = 4'd2;  // commit: read old value
    localparam logic [3:0] S_CWRITE = 4'd3;
    localparam logic [3:0] S_VREAD  = 4'd4;  // judge: read variable v
    localparam logic [3:0] S_DSRCH  = 4'd5;  // judge: search decoration
    localparam logic [3:0] S_PSRCH  = 4'd6;  // judge: search pointer
    localparam logic [3:0] S_SSRCH  = 4'd7;  // judge: search seen bindings
    localparam logic [3:0] S_ISRCH  = 4'd8;  // judge: search sampled images
    localparam logic [3:0] S_RULE   = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0]  state_reg;
    sdbc_req_t   r_reg;
    logic [10:0] idx_reg;      // search counter
    logic        pend_reg;     // a read issued last cycle
    logic        found_reg;
    logic [10:0] hit_reg;
    logic [10:0] v_reg;
    logic [31:0] vkey_reg, vptr_reg, vcls_reg;
    logic [31:0] bind_reg, ptarget_reg;
    logic [2:0]  verdict_reg;
    logic [31:0] fbind_reg;

    // Registered read data.
    logic [31:0] dk_q, pk_q, vk_q, ik_q, sk_q;
    logic [65:0] dv_q;
    logic [63:0] pv_q, vv_q;

    logic [10:0] used_sel;
    logic [31:0] key_sel, key_q;
    logic [1:0]  tsel; // 0 deco, 1 ptr, 2 var/image, 3 seen
    logic        is_img;

    function automatic logic [10:0] capacity(input logic [1:0] t, input logic img);
        logic [10:0] c;
        c = 11'(DECO_ENTRIES);
        if (t == 2'd1) c = 11'(PTR_ENTRIES);
        else if (t == 2'd2) c = img ? 11'(IMAGE_ENTRIES) : 11'(VAR_ENTRIES);
        return c;
    endfunction

    always_comb
    begin
        tsel   = 2'd0;
        is_img = 1'b0;
        key_sel = r_reg.op1;
        used_sel = 11'(deco_used_reg);
        if (state_reg == S_CSRCH || state_reg == S_CREAD || state_reg == S_CWRITE)
        begin
            priority if (r_reg.opcode == OP_DECORATE)
            begin
                tsel = 2'd0; used_sel = 11'(deco_used_reg); key_sel = r_reg.op1;
            end
            else if (r_reg.opcode == OP_TYPE_POINTER)
            begin
                tsel = 2'd1; used_sel = 11'(ptr_used_reg); key_sel = r_reg.op1;
            end
            else if (r_reg.opcode == OP_VARIABLE)
            begin
                tsel = 2'd2; used_sel = 11'(var_used_reg); key_sel = r_reg.op2;
            end
            else
            begin
                tsel = 2'd2; is_img = 1'b1; used_sel = 11'(img_used_reg);
                key_sel = r_reg.op1;
            end
        end
        else if (state_reg == S_DSRCH)
        begin
            tsel = 2'd0; used_sel = 11'(deco_used_reg); key_sel = vkey_reg;
        end
        else if (state_reg == S_PSRCH)
        begin
            tsel = 2'd1; used_sel = 11'(ptr_used_reg); key_sel = vptr_reg;
        end
        else if (state_reg == S_SSRCH)
        begin
            tsel = 2'd3; used_sel = 11'(seen_used_reg); key_sel = bind_reg;
        end
        else if (state_reg == S_ISRCH)
        begin
            tsel = 2'd2; is_img = 1'b1; used_sel = 11'(img_used_reg);
            key_sel = ptarget_reg;
        end
        unique case (tsel)
            2'd0:    key_q = dk_q;
            2'd1:    key_q = pk_q;
            2'd2:    key_q = is_img ? ik_q : vk_q;
            default: key_q = sk_q;
        endcase
    end

    // Memory ports: reads at idx_reg (or hit for value reads / v_reg).
    logic [10:0] raddr;
    logic        wr_deco, wr_ptr, wr_var, wr_img, wr_seen;
    logic [10:0] waddr;
    logic [65:0] deco_wdata;
    logic        new_entry;

    always_comb
    begin
        raddr = idx_reg;
        if (state_reg == S_VREAD) raddr = v_reg;
        else if (state_reg == S_CREAD) raddr = hit_reg;
    end

    always_ff @(posedge clk)
    begin
        dk_q <= deco_key_mem[raddr[DW-1:0]];
        dv_q <= deco_val_mem[raddr[DW-1:0]];
        pk_q <= ptr_key_mem[raddr[PW-1:0]];
        pv_q <= ptr_val_mem[raddr[PW-1:0]];
        vk_q <= var_key_mem[raddr[VW-1:0]];
        vv_q <= var_val_mem[raddr[VW-1:0]];
        ik_q <= img_key_mem[raddr[IW-1:0]];
        sk_q <= seen_mem[raddr[VW-1:0]];
        if (wr_deco) deco_val_mem[waddr[DW-1:0]] <= deco_wdata;
        if (wr_deco && new_entry) deco_key_mem[waddr[DW-1:0]] <= r_reg.op1;
        if (wr_ptr)
        begin
            ptr_key_mem[waddr[PW-1:0]] <= r_reg.op1;
            ptr_val_mem[waddr[PW-1:0]] <= {r_reg.op2, r_reg.op3};
        end
        if (wr_var)
        begin
            var_key_mem[waddr[VW-1:0]] <= r_reg.op2;
            var_val_mem[waddr[VW-1:0]] <= {r_reg.op1, r_reg.op3};
        end
        if (wr_img) img_key_mem[waddr[IW-1:0]] <= r_reg.op1;
        if (wr_seen) seen_mem[waddr[VW-1:0]] <= bind_reg;
    end

    logic [65:0] old_dv;
    always_comb
    begin
        new_entry = !found_reg;
        waddr = found_reg ? hit_reg : used_sel;
        old_dv = found_reg ? dv_q : 66'd0;
        deco_wdata = old_dv;
        if (r_reg.op2 == DEC_BINDING)
        begin
            deco_wdata[65] = 1'b1; deco_wdata[63:32] = r_reg.op3;
        end
        else if (r_reg.op2 == DEC_SET)
        begin
            deco_wdata[64] = 1'b1; deco_wdata[31:0] = r_reg.op3;
        end
        wr_deco = 1'b0; wr_ptr = 1'b0; wr_var = 1'b0; wr_img = 1'b0;
        wr_seen = (state_reg == S_RULE) && (seen_used_reg < (VW+1)'(VAR_ENTRIES));
        if (state_reg == S_SSRCH || state_reg == S_RULE) waddr = 11'(seen_used_reg);
        if (state_reg == S_CWRITE && (found_reg || used_sel < capacity(tsel, is_img)))
        begin
            unique case (tsel)
                2'd0:    wr_deco = 1'b1;
                2'd1:    wr_ptr = 1'b1;
                2'd2:    if (is_img) wr_img = !found_reg; else wr_var = 1'b1;
                default: wr_seen = 1'b0;
            endcase
        end
    end

    // Search step: issue a read each cycle, compare previous read data.
    logic last_issue, cmp_hit;
    assign cmp_hit    = pend_reg && key_q == key_sel;
    assign last_issue = idx_reg >= used_sel;

    logic rule_ok;
    always_comb
    begin
        rule_ok = 1'b0;
        if (vertex_mode && bind_reg == 32'd0) rule_ok = vcls_reg == CLASS_STORAGE_BUFFER;
        else if (vertex_mode && bind_reg == 32'd3) rule_ok = vcls_reg == CLASS_UNIFORM;
        else if (!vertex_mode && bind_reg == 32'd1)
            rule_ok = vcls_reg == CLASS_UNIFORM_CONSTANT && found_reg;
        else if (!vertex_mode && bind_reg == 32'd2) rule_ok = vcls_reg == CLASS_UNIFORM;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            deco_used_reg <= '0; ptr_used_reg <= '0; var_used_reg <= '0;
            img_used_reg <= '0; seen_used_reg <= '0; full_reg <= 1'b0;
            pend_reg <= 1'b0; found_reg <= 1'b0; idx_reg <= '0;
            r_reg <= '0; hit_reg <= '0; v_reg <= '0;
            vkey_reg <= '0; vptr_reg <= '0; vcls_reg <= '0;
            bind_reg <= '0; ptarget_reg <= '0;
            verdict_reg <= VERDICT_OK; fbind_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0; pend_reg <= 1'b0; found_reg <= 1'b0;
                    if (req_valid)
                    begin
                        r_reg <= req;
                        if (req.judge)
                        begin
                            if (req.pre_valid)
                            begin
                                verdict_reg <= req.pre_verdict; fbind_reg <= '0;
                                state_reg <= S_DONE;
                            end
                            else if (full_reg)
                            begin
                                verdict_reg <= VERDICT_OVERFLOW; fbind_reg <= '0;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                v_reg <= '0; verdict_reg <= VERDICT_OK; fbind_reg <= '0;
                                state_reg <= S_VREAD;
                            end
                        end
                        else
                            state_reg <= S_CSRCH;
                    end
                end
                S_CSRCH, S_DSRCH, S_PSRCH, S_SSRCH, S_ISRCH:
                begin
                    if (cmp_hit || (last_issue && !pend_reg) ||
                        (last_issue && pend_reg && !cmp_hit))
                    begin
                        found_reg <= cmp_hit;
                        hit_reg   <= idx_reg - 11'd1;
                        pend_reg  <= 1'b0;
                        idx_reg   <= '0;
                        priority case (state_reg)
                            S_CSRCH: state_reg <= S_CREAD;
                            S_DSRCH:
                            begin
                                // The hit entry's value was read together with
                                // its key, so dv_q already belongs to it.
                                state_reg <= cmp_hit ? S_PSRCH : S_VREAD;
                                if (cmp_hit) bind_reg <= dv_q[63:32];
                                if (!cmp_hit || !dv_q[65])
                                begin
                                    state_reg <= S_VREAD;
                                    v_reg <= v_reg + 11'd1;
                                end
                                else if (!dv_q[64] || dv_q[31:0] != 32'd0)
                                begin
                                    verdict_reg <= VERDICT_BAD_DECL;
                                    state_reg <= S_DONE;
                                end
                            end
                            S_PSRCH:
                            begin
                                ptarget_reg <= pv_q[31:0];
                                if (!cmp_hit || pv_q[63:32] != vcls_reg)
                                begin
                                    verdict_reg <= VERDICT_BAD_DECL;
                                    state_reg <= S_DONE;
                                end
                                else
                                    state_reg <= S_SSRCH;
                            end
                            S_SSRCH:
                            begin
                                if (cmp_hit)
                                begin
                                    verdict_reg <= VERDICT_BAD_DECL;
                                    state_reg <= S_DONE;
                                end
                                else
                                    state_reg <= S_ISRCH;
                            end
                            default: state_reg <= S_RULE;
                        endcase
                    end
                    else
                    begin
                        pend_reg <= 1'b1;
                        idx_reg  <= idx_reg + 11'd1;
                    end
                end
                S_CREAD:
                    state_reg <= S_CWRITE;
                S_CWRITE:
                begin
                    if (!found_reg)
                    begin
                        if (used_sel >= capacity(tsel, is_img))
                            full_reg <= 1'b1;
                        else
                        begin
                            unique case (tsel)
                                2'd0:    deco_used_reg <= deco_used_reg + (DW+1)'(1);
                                2'd1:    ptr_used_reg <= ptr_used_reg + (PW+1)'(1);
                                2'd2:
                                    if (is_img) img_used_reg <= img_used_reg + (IW+1)'(1);
                                    else var_used_reg <= var_used_reg + (VW+1)'(1);
                                default: full_reg <= full_reg;
                            endcase
                        end
                    end
                    state_reg <= S_IDLE;
                end
                S_VREAD:
                begin
                    if (v_reg >= 11'(var_used_reg))
                        state_reg <= S_DONE;
                    else if (pend_reg)
                    begin
                        vkey_reg <= vk_q; vptr_reg <= vv_q[63:32]; vcls_reg <= vv_q[31:0];
                        pend_reg <= 1'b0; idx_reg <= '0;
                        state_reg <= S_DSRCH;
                    end
                    else
                        pend_reg <= 1'b1;
                end
                S_RULE:
                begin
                    if (wr_seen) seen_used_reg <= seen_used_reg + (VW+1)'(1);
                    if (!rule_ok)
                    begin
                        verdict_reg <= VERDICT_BINDING; fbind_reg <= bind_reg;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        v_reg <= v_reg + 11'd1; state_reg <= S_VREAD;
                    end
                end
                S_DONE:
                begin
                    deco_used_reg <= '0; ptr_used_reg <= '0; var_used_reg <= '0;
                    img_used_reg <= '0; seen_used_reg <= '0; full_reg <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy        = state_reg != S_IDLE;
    assign res_valid   = state_reg == S_DONE;
    assign res_verdict = verdict_reg;
    assign res_binding = fbind_reg;

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_used_reg <= var_used_reg) else $error("seen count exceeds variables");
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (var_used_reg == '0 && !full_reg)) else $error("tables not cleared");
    a_req_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid |-> !busy) else $error("request while busy");

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the descriptor binding checker. Directed and
// random word streams are sent through the input stream. A predictor in
// the bench tracks the header, the instruction split and the id tables, and
// works out the verdict of each module. Every result beat is compared with
// the oldest verdict that is still waiting.
// ----------------------------------------------------------------------------
module tb_top;
    import sdbc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DECO_N  = DECO_ENTRIES_DEF;
    localparam int PTR_N   = PTR_ENTRIES_DEF;
    localparam int VAR_N   = VAR_ENTRIES_DEF;
    localparam int IMAGE_N = IMAGE_ENTRIES_DEF;
    localparam int TBL_N   = 64;

    // Expected content of one result beat.
    typedef struct {
        logic [2:0]  verdict;
        logic [31:0] failing_binding;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // module_word
    logic        s_axis_tlast = 1'b0;   // last_word
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // verdict[2:0], failing_binding[34:3], zeros
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    int src_idle = 0;     // percent of cycles the sender leaves a gap
    int dst_idle = 0;     // percent of cycles the receiver stalls
    int hold_left = 0;    // cycles of a long receiver hold-off still to run
    int mismatches = 0;

    verdict_t    verdict_q[$];
    logic [31:0] stream_words[$];

    spirv_descriptor_binding_checker_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor state. It mirrors what the block keeps per stream; all tables
    // share one size and each has its own entry limit.
    // ------------------------------------------------------------------------
    logic        stage_vertex = 1'b1;
    int unsigned hdr_count;
    bit          hdr_bad;
    int unsigned left_words;
    logic [15:0] ins_op;
    logic [15:0] ins_len;
    logic [31:0] arg1, arg2, arg3;
    bit          cut_short;
    bit          overflowed;

    logic [31:0] deco_id[TBL_N], deco_bind[TBL_N], deco_grp[TBL_N];
    bit          deco_has_bind[TBL_N], deco_has_grp[TBL_N];
    logic [31:0] ptr_id[TBL_N], ptr_cls[TBL_N], ptr_tgt[TBL_N];
    logic [31:0] var_id[TBL_N], var_ptr[TBL_N], var_cls[TBL_N];
    logic [31:0] img_id[TBL_N], bound[TBL_N];
    int          deco_cnt, ptr_cnt, var_cnt, img_cnt, bound_cnt;

    function automatic int find_id(input logic [31:0] keys[TBL_N], input int cnt,
                                   input logic [31:0] id);
        for (int i = 0; i < cnt; i++)
            if (keys[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void clear_stream();
        hdr_count = 0; hdr_bad = 0; left_words = 0;
        ins_op = '0; ins_len = '0; arg1 = '0; arg2 = '0; arg3 = '0;
        cut_short = 0; overflowed = 0;
        deco_cnt = 0; ptr_cnt = 0; var_cnt = 0; img_cnt = 0; bound_cnt = 0;
    endfunction

    // Records one finished instruction in its table. A new id that meets a
    // full table is dropped and marks the stream as overflowed.
    function automatic void record_instruction();
        int k;
        if (ins_op == OP_DECORATE && ins_len >= 4)
        begin
            k = find_id(deco_id, deco_cnt, arg1);
            if (k < 0)
            begin
                if (deco_cnt >= DECO_N)
                begin
                    overflowed = 1;
                    return;
                end
                k = deco_cnt++;
                deco_id[k] = arg1;
                deco_has_bind[k] = 0; deco_has_grp[k] = 0;
                deco_bind[k] = '0; deco_grp[k] = '0;
            end
            if (arg2 == DEC_BINDING)
            begin
                deco_bind[k] = arg3; deco_has_bind[k] = 1;
            end
            else if (arg2 == DEC_SET)
            begin
                deco_grp[k] = arg3; deco_has_grp[k] = 1;
            end
        end
        else if (ins_op == OP_TYPE_POINTER && ins_len == 4)
        begin
            k = find_id(ptr_id, ptr_cnt, arg1);
            if (k < 0)
            begin
                if (ptr_cnt >= PTR_N)
                begin
                    overflowed = 1;
                    return;
                end
                k = ptr_cnt++;
                ptr_id[k] = arg1;
            end
            ptr_cls[k] = arg2;
            ptr_tgt[k] = arg3;
        end
        else if (ins_op == OP_TYPE_SAMPLED_IMAGE && ins_len == 3)
        begin
            if (find_id(img_id, img_cnt, arg1) < 0)
            begin
                if (img_cnt >= IMAGE_N)
                begin
                    overflowed = 1;
                    return;
                end
                img_id[img_cnt++] = arg1;
            end
        end
        else if (ins_op == OP_VARIABLE && ins_len >= 4)
        begin
            k = find_id(var_id, var_cnt, arg2);
            if (k < 0)
            begin
                if (var_cnt >= VAR_N)
                begin
                    overflowed = 1;
                    return;
                end
                k = var_cnt++;
                var_id[k] = arg2;
            end
            var_ptr[k] = arg1;
            var_cls[k] = arg3;
        end
    endfunction

    function automatic void track_word(input logic [31:0] w);
        int unsigned pos;
        if (hdr_count < 5)
        begin
            if (hdr_count == 0 && w != MAGIC_WORD)
                hdr_bad = 1;
            hdr_count++;
            return;
        end
        if (cut_short)
            return;
        if (left_words == 0)
        begin
            ins_len = w[31:16];
            ins_op  = w[15:0];
            if (ins_len == 0)
            begin
                cut_short = 1;
                return;
            end
            arg1 = '0; arg2 = '0; arg3 = '0;
            left_words = ins_len - 1;
            if (left_words == 0)
                record_instruction();
            return;
        end
        pos = ins_len - 1 - left_words;
        if (pos == 0)
            arg1 = w;
        else if (pos == 1)
            arg2 = w;
        else if (pos == 2)
            arg3 = w;
        left_words--;
        if (left_words == 0)
            record_instruction();
    endfunction

    // Final check of a stream: header, truncation, overflow, then every bound
    // variable in the order it was first declared.
    function automatic verdict_t settle_verdict();
        verdict_t r;
        int d, p;
        logic [31:0] b, c;
        bit ok;
        r.verdict = VERDICT_OK;
        r.failing_binding = '0;
        if (hdr_bad || hdr_count < 5)
        begin
            r.verdict = VERDICT_BAD_HEADER;
            return r;
        end
        if (cut_short || left_words != 0)
        begin
            r.verdict = VERDICT_TRUNCATED;
            return r;
        end
        if (overflowed)
        begin
            r.verdict = VERDICT_OVERFLOW;
            return r;
        end
        for (int v = 0; v < var_cnt; v++)
        begin
            d = find_id(deco_id, deco_cnt, var_id[v]);
            if (d < 0 || !deco_has_bind[d])
                continue;
            b = deco_bind[d];
            c = var_cls[v];
            p = find_id(ptr_id, ptr_cnt, var_ptr[v]);
            if (!deco_has_grp[d] || deco_grp[d] != 0 || p < 0 || ptr_cls[p] != c ||
                find_id(bound, bound_cnt, b) >= 0)
            begin
                r.verdict = VERDICT_BAD_DECL;
                return r;
            end
            if (bound_cnt < VAR_N)
                bound[bound_cnt++] = b;
            ok = 0;
            if (stage_vertex && b == 0)
                ok = (c == CLASS_STORAGE_BUFFER);
            else if (stage_vertex && b == 3)
                ok = (c == CLASS_UNIFORM);
            else if (!stage_vertex && b == 1)
                ok = (c == CLASS_UNIFORM_CONSTANT) &&
                     (find_id(img_id, img_cnt, ptr_tgt[p]) >= 0);
            else if (!stage_vertex && b == 2)
                ok = (c == CLASS_UNIFORM);
            if (!ok)
            begin
                r.verdict = VERDICT_BINDING;
                r.failing_binding = b;
                return r;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result side. The receiver stalls at random, or for a long stretch while
    // hold_left counts down; every accepted beat is checked on the spot.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result beat with no verdict expected: %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                exp_v = verdict_q.pop_front();
                if (m_axis_tdata[2:0] !== exp_v.verdict)
                begin
                    $error("verdict: expected %0d, got %0d", exp_v.verdict,
                           m_axis_tdata[2:0]);
                    mismatches++;
                end
                if (m_axis_tdata[34:3] !== exp_v.failing_binding)
                begin
                    $error("failing_binding: expected %0d, got %0d",
                           exp_v.failing_binding, m_axis_tdata[34:3]);
                    mismatches++;
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= rst_n && ($urandom_range(99) >= dst_idle);
    end

    // ------------------------------------------------------------------------
    // Sender. Valid stays high from one beat to the next unless a gap is
    // drawn; the predictor sees each word at the edge that accepts it.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [31:0] w, input bit last);
        while ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        track_word(w);
        if (last)
        begin
            verdict_q.push_back(settle_verdict());
            clear_stream();
        end
    endtask

    task automatic send_stream();
        foreach (stream_words[i])
            send_word(stream_words[i], i == stream_words.size() - 1);
    endtask

    // Waits until every verdict has arrived and the block has settled.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic set_stage(input logic vertex);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= vertex;
        do
            @(posedge clk);
        while (!cfg_ready);
        stage_vertex = vertex;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stream builders.
    // ------------------------------------------------------------------------
    task automatic start_module();
        stream_words.delete();
        stream_words.push_back(MAGIC_WORD);
        repeat (4) stream_words.push_back($urandom());
    endtask

    // Appends one instruction; operands past the third are random.
    task automatic add_ins(input logic [15:0] op, input int len,
                           input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] c);
        stream_words.push_back({16'(len), op});
        for (int i = 1; i < len; i++)
            stream_words.push_back(i == 1 ? a : i == 2 ? b : i == 3 ? c : $urandom());
    endtask

    // One fully declared resource: pointer, optional image, variable and
    // both decorations.
    task automatic add_resource(input logic [31:0] vid, input logic [31:0] pid,
                                input logic [31:0] cls, input logic [31:0] bind_no,
                                input bit with_image);
        add_ins(OP_TYPE_POINTER, 4, pid, cls, pid + 100);
        if (with_image)
            add_ins(OP_TYPE_SAMPLED_IMAGE, 3, pid + 100, $urandom(), 0);
        add_ins(OP_VARIABLE, 4, pid, vid, cls);
        add_ins(OP_DECORATE, 4, vid, DEC_BINDING, bind_no);
        add_ins(OP_DECORATE, 4, vid, DEC_SET, 0);
    endtask

    function automatic logic [31:0] pick_class();
        case ($urandom_range(7))
            0, 1:    return CLASS_UNIFORM_CONSTANT;
            2, 3:    return CLASS_UNIFORM;
            4, 5:    return CLASS_STORAGE_BUFFER;
            default: return $urandom_range(15);
        endcase
    endfunction

    // A module with random resources; most are well formed, some are
    // damaged in the header, the declarations or the instruction split.
    task automatic build_random_module();
        int nres;
        logic [31:0] vid, pid, tgt, cls;
        start_module();
        nres = $urandom_range(0, 3);
        for (int r = 0; r < nres; r++)
        begin
            vid = $urandom_range(1, 12);
            pid = $urandom_range(20, 27);
            tgt = $urandom_range(40, 43);
            cls = pick_class();
            add_ins(OP_TYPE_POINTER, ($urandom_range(9) == 0) ? 5 : 4, pid,
                    ($urandom_range(9) == 0) ? pick_class() : cls, tgt);
            if ($urandom_range(1))
                add_ins(OP_TYPE_SAMPLED_IMAGE, ($urandom_range(9) == 0) ? 4 : 3,
                        tgt, $urandom(), 0);
            add_ins(OP_VARIABLE, $urandom_range(4, 5), pid, vid, cls);
            if ($urandom_range(7) != 0)
                add_ins(OP_DECORATE, 4, vid, DEC_BINDING,
                        ($urandom_range(15) == 0) ? $urandom() : $urandom_range(0, 4));
            case ($urandom_range(9))
                0:       ;
                1:       add_ins(OP_DECORATE, 4, vid, DEC_SET, $urandom_range(1, 3));
                default: add_ins(OP_DECORATE, $urandom_range(4, 5), vid, DEC_SET, 0);
            endcase
            if ($urandom_range(3) == 0)
                add_ins(16'($urandom()), $urandom_range(1, 5), $urandom(), $urandom(),
                        $urandom());
        end
        case ($urandom_range(19))
            0: stream_words[0] = $urandom();
            1: stream_words.push_back({16'h0, 16'($urandom())});
            2: stream_words.push_back($urandom());
            3: repeat ($urandom_range(1, 6)) void'(stream_words.pop_back());
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------
    task automatic test_header();
        // A module shorter than its header.
        stream_words = '{MAGIC_WORD, 32'hFFFF_FFFF, 32'h0};
        send_stream();
        // Wrong magic, then a bare header that passes.
        start_module();
        stream_words[0] = ~MAGIC_WORD;
        send_stream();
        start_module();
        send_stream();
    endtask

    task automatic test_split_errors();
        // A zero word count stops the split; later words are ignored.
        start_module();
        stream_words.push_back({16'h0, OP_DECORATE});
        stream_words.push_back(32'hFFFF_FFFF);
        send_stream();
        // The last word leaves an instruction unfinished.
        start_module();
        add_ins(OP_VARIABLE, 4, 1, 2, 3);
        void'(stream_words.pop_back());
        send_stream();
        // Tracked opcodes with the wrong count are skipped; a decoration
        // of another kind still takes an entry.
        start_module();
        add_ins(OP_TYPE_POINTER, 3, 5, CLASS_UNIFORM, 0);
        add_ins(OP_DECORATE, 5, 7, 32'd6, 1);
        add_ins(OP_VARIABLE, 3, 5, 7, CLASS_UNIFORM);
        send_stream();
    endtask

    task automatic test_stage_rules(input logic vertex);
        set_stage(vertex);
        // Every listed binding with its proper class.
        start_module();
        add_resource(1, 21, CLASS_STORAGE_BUFFER, 0, 0);
        add_resource(2, 22, CLASS_UNIFORM, 3, 0);
        add_resource(3, 23, CLASS_UNIFORM_CONSTANT, 1, 1);
        add_resource(4, 24, CLASS_UNIFORM, 2, 0);
        send_stream();
        // A binding that no stage rule names.
        start_module();
        add_resource(1, 21, CLASS_UNIFORM, 32'hFFFF_FFFF, 0);
        send_stream();
        // A sampler without its image type.
        start_module();
        add_resource(1, 21, CLASS_UNIFORM_CONSTANT, 1, 0);
        send_stream();
        // Repeated binding; a later decoration overwrites the first.
        start_module();
        add_resource(1, 21, CLASS_UNIFORM, 2, 0);
        add_resource(2, 22, CLASS_UNIFORM, 2, 0);
        add_ins(OP_DECORATE, 4, 2, DEC_BINDING, 3);
        send_stream();
    endtask

    task automatic test_overflow();
        start_module();
        for (int i = 0; i <= IMAGE_N; i++)
            add_ins(OP_TYPE_SAMPLED_IMAGE, 3, 200 + i, 0, 0);
        send_stream();
    endtask

    task automatic test_random(input int modules);
        for (int m = 0; m < modules; m++)
        begin
            if (m % 10 == 9)
                set_stage($urandom_range(1));
            build_random_module();
            send_stream();
        end
    endtask

    // The receiver holds off while three modules go in: the second stalls at
    // its last word behind the result still waiting in the output register.
    task automatic test_backpressure();
        wait_idle();
        hold_left = 400;
        repeat (3)
        begin
            build_random_module();
            send_stream();
        end
    endtask

    initial
    begin
        clear_stream();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header();
        test_split_errors();
        test_stage_rules(1'b1);
        test_stage_rules(1'b0);
        test_overflow();

        src_idle = 35; dst_idle = 53;
        test_random(2);
        src_idle = 53; dst_idle = 35;
        test_random(2);
        src_idle = 0; dst_idle = 0;
        test_random(2);
        test_backpressure();
        set_stage(1'b1);
        test_random(1);

        wait_idle();
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
